// ===== hdl/wildcard_byte_signature_scanner_unit_defines.svh =====
// assertion macros for the wildcard byte signature scanner
`ifndef WILDCARD_BYTE_SIGNATURE_SCANNER_UNIT_DEFINES_SVH
`define WILDCARD_BYTE_SIGNATURE_SCANNER_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, disabled in reset
`define WBSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wildcard scanner: check failed");
// next-cycle implication, disabled in reset
`define WBSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wildcard scanner: check failed");
`else
`define WBSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define WBSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/wbss_pkg.sv =====
// shared types and constants for the wildcard byte signature scanner
`default_nettype none

package wbss_pkg;

  localparam int DATA_W     = 8;
  localparam int ADDR_W     = 48;
  localparam int OFFSET_W   = 32;
  localparam int LEN_W      = 5;
  localparam int MASK_W     = 16;
  localparam int PAT_W      = 64;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  // positions of the flags in in_tuser
  localparam int TUSER_REGION_FIRST = 0;
  localparam int TUSER_SCAN_FIRST   = 1;
  localparam int IN_TUSER_W         = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_WILDCARD_MASK  = 3'd2,
    REG_PAT_LEN        = 3'd3,
    REG_MATCH_OFFSET   = 3'd4
  } cfg_reg_t;

  // per-cell shift control
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/wildcard_byte_signature_scanner_unit.sv =====
// Wildcard byte signature scanner: takes one memory byte per beat with its address and
// region/scan flags, and reports the first place in a scan where the newest bytes of the
// current region, as many as the configured pattern length, match the configured pattern
// (masked bytes match anything), or a miss at the scan's last byte. A byte is accepted
// every cycle unless the input stalls; its result, if any, passes from the compare stage
// to the output register once that is free. The rate is set by the row of window cells,
// which shift one byte per beat, and the compare stage behind them, which checks all cells
// at once. The input stalls only when both the compare stage and the output register hold
// a beat and the output is not taken. Derived pattern values are re-registered every
// cycle, so a configuration write takes effect for bytes accepted from the next cycle on.
`default_nettype none
`include "wildcard_byte_signature_scanner_unit_defines.svh"

module wildcard_byte_signature_scanner_unit #(
  parameter int PATTERN_MAX  = 16,
  parameter int ADDRESS_BITS = 48
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // input stream
  input  wire logic                                          in_tvalid,
  output logic                                               in_tready,
  // data_byte [7:0], byte_address [55:8]
  input  wire logic [wbss_pkg::DATA_W+wbss_pkg::ADDR_W-1:0] in_tdata,
  // region_first [0], scan_first [1]
  input  wire logic [wbss_pkg::IN_TUSER_W-1:0]              in_tuser,
  input  wire logic                                          in_tlast,
  // result stream
  output logic                                               out_tvalid,
  input  wire logic                                          out_tready,
  // match_address [47:0]
  output logic      [wbss_pkg::ADDR_W-1:0]                   out_tdata,
  // found [0]
  output logic      [0:0]                                    out_tuser,
  // configuration writes
  input  wire logic                                          cfg_valid,
  output logic                                               cfg_ready,
  input  wire logic [wbss_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  wire logic [wbss_pkg::CFG_DATA_W-1:0]               cfg_data
);

  localparam int DW     = wbss_pkg::DATA_W;
  localparam int AW     = wbss_pkg::ADDR_W;
  localparam int LW     = wbss_pkg::LEN_W;
  localparam int FILL_W = $clog2(PATTERN_MAX + 1);
  localparam int AW_EFF = (ADDRESS_BITS < AW) ? ADDRESS_BITS : AW;
  localparam logic [AW-1:0] ADDR_MASK = {AW{1'b1}} >> (AW - AW_EFF);

  // configuration registers
  logic [wbss_pkg::PAT_W-1:0]    pat_low_r, pat_low_nxt;
  logic [wbss_pkg::PAT_W-1:0]    pat_high_r, pat_high_nxt;
  logic [wbss_pkg::MASK_W-1:0]   wild_r, wild_nxt;
  logic [LW-1:0]                 len_r, len_nxt;
  logic [wbss_pkg::OFFSET_W-1:0] offset_r, offset_nxt;

  logic cfg_fire;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // register write decode
  always_comb begin
    pat_low_nxt  = pat_low_r;
    pat_high_nxt = pat_high_r;
    wild_nxt     = wild_r;
    len_nxt      = len_r;
    offset_nxt   = offset_r;
    if (cfg_fire) begin
      unique case (wbss_pkg::cfg_reg_t'(cfg_index))
        wbss_pkg::REG_PATTERN_LOW:    pat_low_nxt  = cfg_data;
        wbss_pkg::REG_PATTERN_HIGH:   pat_high_nxt = cfg_data;
        wbss_pkg::REG_WILDCARD_MASK:  wild_nxt     = cfg_data[wbss_pkg::MASK_W-1:0];
        wbss_pkg::REG_PAT_LEN:        len_nxt      = cfg_data[LW-1:0];
        wbss_pkg::REG_MATCH_OFFSET:   offset_nxt   = cfg_data[wbss_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      wild_r     <= '0;
      len_r      <= LW'(1);
      offset_r   <= '0;
    end else begin
      pat_low_r  <= pat_low_nxt;
      pat_high_r <= pat_high_nxt;
      wild_r     <= wild_nxt;
      len_r      <= len_nxt;
      offset_r   <= offset_nxt;
    end
  end

  // active length: zero acts as one, clamp at the window depth
  logic [LW-1:0] n_act;
  always_comb begin
    if (len_r == '0) begin
      n_act = LW'(1);
    end else if (len_r > LW'(PATTERN_MAX)) begin
      n_act = LW'(PATTERN_MAX);
    end else begin
      n_act = len_r;
    end
  end

  // derived values, registered every cycle
  logic [LW-1:0] n_r;
  logic [AW-1:0] adj_r, adj_nxt;
  assign adj_nxt = {{(AW - wbss_pkg::OFFSET_W){offset_r[wbss_pkg::OFFSET_W-1]}}, offset_r}
                   - AW'(n_act - LW'(1));

  always_ff @(posedge clk) begin
    n_r   <= n_act;
    adj_r <= adj_nxt;
  end

  // handshakes
  logic in_fire, p_adv;
  logic p_valid_r, p_valid_nxt;
  logic out_valid_r, out_valid_nxt;

  assign p_adv     = !out_valid_r || out_tready;
  assign in_tready = !p_valid_r || p_adv;
  assign in_fire   = in_tvalid && in_tready;

  // window fill count
  logic [FILL_W-1:0] fill_r, fill_nxt;
  always_comb begin
    fill_nxt = fill_r;
    if (in_fire) begin
      if (in_tuser[wbss_pkg::TUSER_REGION_FIRST]) begin
        fill_nxt = FILL_W'(1);
      end else if (fill_r != FILL_W'(PATTERN_MAX)) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  // row of window cells, cell 0 holds the newest byte
  logic [127:0]               pat_all;
  logic [DW-1:0]              cell_byte [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]     hit;
  wbss_pkg::cell_ctrl_t       ctrl_head, ctrl_body;

  assign pat_all         = {pat_high_r, pat_low_r};
  assign ctrl_head.shift = in_fire;
  assign ctrl_head.clear = 1'b0;
  assign ctrl_body.shift = in_fire;
  assign ctrl_body.clear = in_tuser[wbss_pkg::TUSER_REGION_FIRST];

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic [LW-1:0] pidx;
    logic [DW-1:0] exp_b;
    logic          care_b;
    logic [DW-1:0] byte_src;

    // cell j meets pattern byte n-1-j
    assign pidx   = n_act - LW'(j + 1);
    assign exp_b  = pat_all[{pidx[3:0], 3'b000} +: DW];
    assign care_b = (LW'(j) < n_act) && !wild_r[pidx[3:0]];

    if (j == 0) begin : g_head
      assign byte_src = in_tdata[DW-1:0];
      wbss_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl_head),
        .byte_in  (byte_src),
        .exp_in   (exp_b),
        .care_in  (care_b),
        .byte_out (cell_byte[j]),
        .hit      (hit[j])
      );
    end else begin : g_body
      assign byte_src = cell_byte[j-1];
      wbss_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl_body),
        .byte_in  (byte_src),
        .exp_in   (exp_b),
        .care_in  (care_b),
        .byte_out (cell_byte[j]),
        .hit      (hit[j])
      );
    end
  end

  // compare stage: beat whose byte sits in cell 0
  logic [AW-1:0] p_addr_r, p_addr_nxt;
  logic          p_sfirst_r, p_sfirst_nxt;
  logic          p_last_r, p_last_nxt;

  always_comb begin
    p_valid_nxt  = p_valid_r;
    p_addr_nxt   = p_addr_r;
    p_sfirst_nxt = p_sfirst_r;
    p_last_nxt   = p_last_r;
    if (in_tready) begin
      p_valid_nxt  = in_fire;
      p_addr_nxt   = in_tdata[DW +: AW];
      p_sfirst_nxt = in_tuser[wbss_pkg::TUSER_SCAN_FIRST];
      p_last_nxt   = in_tlast;
    end
  end

  // match decision and scan state
  logic seen_r, seen_nxt, seen_eff;
  logic hit_match, emit;
  logic [AW-1:0] match_addr;

  assign seen_eff   = p_sfirst_r ? 1'b0 : seen_r;
  assign hit_match  = (&hit) && (LW'(fill_r) >= n_r);
  assign emit       = !seen_eff && (hit_match || p_last_r);
  assign match_addr = (p_addr_r + adj_r) & ADDR_MASK;

  always_comb begin
    seen_nxt = seen_r;
    if (p_valid_r && p_adv) begin
      seen_nxt = seen_eff || emit;
    end
  end

  // output register
  logic          out_found_r, out_found_nxt;
  logic [AW-1:0] out_addr_r, out_addr_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    if (p_adv) begin
      out_valid_nxt = p_valid_r && emit;
      out_found_nxt = hit_match;
      out_addr_nxt  = hit_match ? match_addr : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      p_valid_r   <= 1'b0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      p_valid_r   <= p_valid_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_addr_r    <= p_addr_nxt;
    p_sfirst_r  <= p_sfirst_nxt;
    p_last_r    <= p_last_nxt;
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_addr_r;
  assign out_tuser[0] = out_found_r;

  // checks
  `WBSS_ASSERT_NEXT(a_emit_reaches_out, clk, rst_n, p_valid_r && p_adv && emit, out_valid_r)
  `WBSS_ASSERT_NEXT(a_emit_sets_seen, clk, rst_n, p_valid_r && p_adv && emit, seen_r)
  `WBSS_ASSERT_IMPL(a_notfound_zero, clk, rst_n, out_valid_r && !out_found_r, out_addr_r == '0)
  `WBSS_ASSERT_NEXT(a_region_restarts_fill, clk, rst_n, in_fire && ctrl_body.clear, fill_r == FILL_W'(1))

endmodule

`default_nettype wire

// ===== hdl/wbss_cell.sv =====
// one window cell: holds a byte and its expected pattern byte, passes the byte on
`default_nettype none

module wbss_cell (
  input  wire logic                       clk,
  input  wire wbss_pkg::cell_ctrl_t       ctrl,
  input  wire logic [wbss_pkg::DATA_W-1:0] byte_in,
  input  wire logic [wbss_pkg::DATA_W-1:0] exp_in,
  input  wire logic                       care_in,
  output logic      [wbss_pkg::DATA_W-1:0] byte_out,
  output logic                            hit
);

  logic [wbss_pkg::DATA_W-1:0] byte_r, byte_nxt;
  logic [wbss_pkg::DATA_W-1:0] exp_r;
  logic                        care_r;

  // shift in the neighbour's byte, or zero when a region starts
  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.shift) begin
      byte_nxt = ctrl.clear ? '0 : byte_in;
    end
  end

  // pattern byte and care flag follow the registers every cycle; the window byte changes only on a shift
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    exp_r  <= exp_in;
    care_r <= care_in;
  end

  assign byte_out = byte_r;
  assign hit      = !care_r || (byte_r == exp_r);

endmodule

`default_nettype wire

// ===== bench/wildcard_byte_signature_scanner_unit_tb.sv =====
// self-checking testbench for the wildcard byte signature scanner, with its own scan predictor
`default_nettype none

module wildcard_byte_signature_scanner_unit_tb;

  localparam int DATA_W             = wbss_pkg::DATA_W;
  localparam int ADDR_W             = wbss_pkg::ADDR_W;
  localparam int IN_TUSER_W         = wbss_pkg::IN_TUSER_W;
  localparam int CFG_DATA_W         = wbss_pkg::CFG_DATA_W;
  localparam int PAT_W              = wbss_pkg::PAT_W;
  localparam int MASK_W             = wbss_pkg::MASK_W;
  localparam int LEN_W              = wbss_pkg::LEN_W;
  localparam int OFFSET_W           = wbss_pkg::OFFSET_W;
  localparam int TUSER_REGION_FIRST = wbss_pkg::TUSER_REGION_FIRST;
  localparam int TUSER_SCAN_FIRST   = wbss_pkg::TUSER_SCAN_FIRST;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PAT_BYTES      = 16;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } scan_result_t;

  // clock, reset and block ports
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_W+ADDR_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ADDR_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  wbss_pkg::cfg_reg_t cfg_index = wbss_pkg::REG_PATTERN_LOW;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the registers and the window
  logic [PAT_W-1:0] cur_pat_lo = '0;
  logic [PAT_W-1:0] cur_pat_hi = '0;
  logic [MASK_W-1:0] cur_mask = '0;
  logic [LEN_W-1:0] cur_len = 5'd1;
  logic [OFFSET_W-1:0] cur_offset = '0;
  logic [7:0] win [PAT_BYTES];
  int win_fill = 0;
  logic match_done = 1'b0;

  scan_result_t pending_results[$];
  int mismatch_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;

  wildcard_byte_signature_scanner_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // pattern length as the block uses it
  function automatic int active_len();
    if (cur_len == 0) return 1;
    if (cur_len > PAT_BYTES) return PAT_BYTES;
    return int'(cur_len);
  endfunction

  function automatic logic [7:0] pattern_byte(input int i);
    if (i < 8) return cur_pat_lo[8*i +: 8];
    return cur_pat_hi[8*(i-8) +: 8];
  endfunction

  // window update and match decision for one accepted byte
  task automatic predict_scan_step(input logic [7:0] data, input logic [ADDR_W-1:0] addr,
                                   input logic rf, input logic sf, input logic sl);
    int n;
    logic hit;
    scan_result_t res;
    n = active_len();
    if (sf) match_done = 1'b0;
    if (rf) begin
      foreach (win[k]) win[k] = 8'h00;
      win_fill = 0;
    end
    for (int k = PAT_BYTES - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = data;
    if (win_fill < PAT_BYTES) win_fill++;
    if (!match_done) begin
      // oldest byte of the window lines up with pattern byte 0
      hit = (win_fill >= n);
      for (int i = 0; i < n; i++) begin
        if (!cur_mask[i] && win[n-1-i] != pattern_byte(i)) hit = 1'b0;
      end
      if (hit) begin
        match_done = 1'b1;
        res.found = 1'b1;
        res.addr = addr - ADDR_W'(n - 1) + {{(ADDR_W-OFFSET_W){cur_offset[OFFSET_W-1]}},
                                            cur_offset};
        pending_results.push_back(res);
      end else if (sl) begin
        match_done = 1'b1;
        res = '0;
        pending_results.push_back(res);
      end
    end
  endtask

  // one input beat, with an optional gap in front of it
  task automatic send_byte(input logic [7:0] data, input logic [ADDR_W-1:0] addr,
                           input logic rf, input logic sf, input logic sl);
    logic [IN_TUSER_W-1:0] flags;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    flags = '0;
    flags[TUSER_REGION_FIRST] = rf;
    flags[TUSER_SCAN_FIRST] = sf;
    in_tvalid <= 1'b1;
    in_tdata <= {addr, data};
    in_tuser <= flags;
    in_tlast <= sl;
    do @(posedge clk); while (!in_tready);
    predict_scan_step(data, addr, rf, sf, sl);
    items_sent++;
  endtask

  // sender holds off until every expected result is out
  task automatic drain_results;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // drained and past the pipeline, safe for register writes
  task automatic settle;
    drain_results();
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_beat(input wbss_pkg::cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      wbss_pkg::REG_PATTERN_LOW:   cur_pat_lo = val;
      wbss_pkg::REG_PATTERN_HIGH:  cur_pat_hi = val;
      wbss_pkg::REG_WILDCARD_MASK: cur_mask = val[MASK_W-1:0];
      wbss_pkg::REG_PAT_LEN:       cur_len = val[LEN_W-1:0];
      wbss_pkg::REG_MATCH_OFFSET:  cur_offset = val[OFFSET_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [63:0] plo, input logic [63:0] phi,
                            input logic [15:0] mask, input logic [4:0] len,
                            input logic [31:0] offset);
    cfg_beat(wbss_pkg::REG_PATTERN_LOW, plo);
    cfg_beat(wbss_pkg::REG_PATTERN_HIGH, phi);
    cfg_beat(wbss_pkg::REG_WILDCARD_MASK, 64'(mask));
    cfg_beat(wbss_pkg::REG_PAT_LEN, 64'(len));
    cfg_beat(wbss_pkg::REG_MATCH_OFFSET, 64'(offset));
    cfg_valid <= 1'b0;
  endtask

  // registers as left by reset: one-byte pattern of zero, no offset
  task automatic test_reset_defaults;
    send_byte(8'h05, 48'h0000_1000_0000, 1'b1, 1'b1, 1'b0);
    send_byte(8'h00, 48'h0000_1000_0001, 1'b0, 1'b0, 1'b0);
    // bytes after the result give nothing, even the scan end
    send_byte(8'hFF, 48'h0000_1000_0002, 1'b0, 1'b0, 1'b1);
  endtask

  // wildcard inside the pattern, region breaks and address wrap
  task automatic test_wildcards_and_regions;
    settle();
    // byte 1 wild, mask bits past the length ignored, offset -5
    set_config(64'h0000_0000_4433_2211, 64'h0123_4567_89AB_CDEF, 16'hF002, 5'd4,
               32'hFFFF_FFFB);
    // pattern split over two regions must not match
    send_byte(8'h11, 48'h0000_0000_0010, 1'b1, 1'b1, 1'b0);
    send_byte(8'hAA, 48'h0000_0000_0011, 1'b0, 1'b0, 1'b0);
    send_byte(8'h33, 48'h0000_0000_0012, 1'b1, 1'b0, 1'b0);
    send_byte(8'h44, 48'h0000_0000_2000, 1'b0, 1'b0, 1'b1);
    // match on the scan's last byte, start wraps below zero
    send_byte(8'h11, 48'hFFFF_FFFF_FFFE, 1'b1, 1'b1, 1'b0);
    send_byte(8'h5A, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0);
    send_byte(8'h33, 48'h0000_0000_0000, 1'b0, 1'b0, 1'b0);
    send_byte(8'h44, 48'h0000_0000_0001, 1'b0, 1'b0, 1'b1);
  endtask

  // length above the maximum, length zero, offset extremes
  task automatic test_length_extremes;
    logic [ADDR_W-1:0] base;
    settle();
    // all wildcard: only a full window of sixteen may match
    set_config('1, '1, 16'hFFFF, 5'd31, 32'h7FFF_FFFF);
    base = 48'hFFFF_FFFF_FFF8;
    for (int j = 0; j < PAT_BYTES; j++) begin
      send_byte(8'($urandom), base + ADDR_W'(j), j == 0, j == 0, 1'b0);
    end
    settle();
    set_config(64'h0000_0000_0000_00FF, '0, '0, 5'd0, 32'h8000_0000);
    send_byte(8'hFF, 48'h0000_0000_1234, 1'b1, 1'b1, 1'b1);
  endtask

  // pattern bytes drawn so that zero and all-ones bytes are common
  function automatic logic [7:0] pattern_pick();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_config;
    logic [63:0] plo, phi;
    logic [4:0] len;
    logic [31:0] offset;
    for (int i = 0; i < 8; i++) begin
      plo[8*i +: 8] = pattern_pick();
      phi[8*i +: 8] = pattern_pick();
    end
    if ($urandom_range(0, 9) == 0)
      len = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
    else if ($urandom_range(0, 3) == 0)
      len = 5'($urandom_range(1, 16));
    else
      len = 5'($urandom_range(1, 5));
    case ($urandom_range(0, 7))
      0: offset = 32'h8000_0000;
      1: offset = 32'h7FFF_FFFF;
      2: offset = '0;
      default: offset = $urandom;
    endcase
    set_config(plo, phi, 16'($urandom & $urandom & $urandom), len, offset);
  endtask

  // one scan of a few regions, often with the pattern planted in it
  task automatic random_scan;
    int nreg, rlen, pos, n;
    logic [ADDR_W-1:0] base;
    logic [7:0] b;
    logic plant, rf, sf, sl;
    n = active_len();
    nreg = $urandom_range(1, 3);
    for (int r = 0; r < nreg; r++) begin
      rlen = $urandom_range(1, n + 8);
      base[47:32] = 16'($urandom);
      base[31:0] = $urandom;
      plant = (rlen >= n) && ($urandom_range(0, 1) == 1);
      pos = plant ? $urandom_range(0, rlen - n) : 0;
      for (int j = 0; j < rlen; j++) begin
        if (plant && j >= pos && j < pos + n && !cur_mask[j-pos])
          b = pattern_byte(j - pos);
        else if ($urandom_range(0, 2) == 0)
          b = 8'($urandom);
        else
          b = pattern_byte($urandom_range(0, n - 1));
        rf = (j == 0);
        sf = (r == 0 && j == 0);
        sl = (r == nreg - 1 && j == rlen - 1);
        // occasional stray flags
        if ($urandom_range(0, 15) == 0) begin
          rf = 1'($urandom_range(0, 1));
          sf = 1'($urandom_range(0, 1));
          sl = 1'($urandom_range(0, 1));
        end
        send_byte(b, base + ADDR_W'(j), rf, sf, sl);
      end
    end
  endtask

  task automatic test_random_scans;
    int phase_start;
    bit paused;
    paused = 1'b0;
    for (int phase = 0; phase < 8; phase++) begin
      // last phase runs flat out on both sides
      if (phase == 7) begin
        idle_on = 1'b0;
        stall_on = 1'b0;
      end
      settle();
      random_config();
      phase_start = items_sent;
      while (items_sent - phase_start < 44) begin
        random_scan();
        if (phase == 3 && !paused && items_sent - phase_start >= 22) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end
  endtask

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (!stall_on) begin
      stall_left = 0;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic note_mismatch(input string what, input scan_result_t want);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch (%s): expected found=%0b addr=%h, got found=%0b addr=%h",
               what, want.found, want.addr, out_tuser[0], out_tdata);
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    scan_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[0] !== want.found) note_mismatch("found flag", want);
        else if (out_tdata !== want.addr) note_mismatch("match address", want);
      end
    end
  end

  // stop if no beat moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (win[k]) win[k] = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_wildcards_and_regions();
    test_length_extremes();
    test_random_scans();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/wbss_pkg.sv
hdl/wbss_cell.sv
hdl/wildcard_byte_signature_scanner_unit.sv
bench/wildcard_byte_signature_scanner_unit_tb.sv
